// ===== design/ptrgb_pkg.sv =====
`timescale 1ns / 1ps
// Package for the planar tile to RGB pixel decoder.
// Holds sheet geometry, register indexes and the types shared by the decoder modules.
package ptrgb_pkg;

	localparam int SHEET_WIDTH   = 128;
	localparam int SHEET_HEIGHT  = 128;
	localparam int TILES_PER_ROW = SHEET_WIDTH / 8;
	localparam int TILES_PER_COL = SHEET_HEIGHT / 8;

	localparam int COORD_W = 7;
	localparam int TX_W    = COORD_W - 3;
	localparam int COLOR_W = 24;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_COLOR_ZERO  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COLOR_ONE   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_COLOR_TWO   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COLOR_THREE = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_START_TILE  = 3'd4;

	typedef logic [3:0][COLOR_W-1:0] palette_t;

	// One row of eight pixels waiting to be emitted.
	typedef struct packed {
		logic [7:0]         hi;
		logic [7:0]         lo;
		logic [TX_W-1:0]    tx;
		logic [COORD_W-1:0] y;
	} row_job_t;

	typedef struct packed {
		logic pend;
		logic act;
	} emit_status_t;

endpackage

// ===== design/planar_tile_to_rgb_pixels_top.sv =====
`timescale 1ns / 1ps
// Top level of the planar tile to RGB pixel decoder.
// Depends on ptrgb_pkg and ptrgb_emit.
//
// Usage:
//   Input channel (in_valid / in_stall) carries tile bytes, 16 per tile: eight
//   low-plane rows, then eight high-plane rows. first_of_range restarts at byte 0
//   of the tile slot held in the start_tile register.
//   Output channel (out_valid / out_stall) carries one pixel per transaction:
//   sheet x/y, the RGB of the palette entry picked by the two plane bits, and
//   row_done on the eighth pixel of each row.
//   Configuration: cfg_we writes cfg_data to register cfg_index (0..3 palette,
//   4 start tile); other indexes are dropped. Write only while idle.
// Timing:
//   A low-plane byte is stored and yields nothing. A high-plane byte enters the
//   queue slot, moves to the active row once the emitter is free, and each pixel
//   passes the output register; then one pixel per cycle while the output is not
//   stalled. The emitter holds one active and one queued row; in_stall is high
//   while the queue slot is full. Rows of a tile follow with no gap, but each
//   tile's first row refills the empty emitter, leaving a gap before its pixels.
// Reset clears palette, start tile, byte position, tile slot and all valids.
// A stalled receiver holds the output register; the emitter and then the input
// back up behind it without losing a transaction.
module planar_tile_to_rgb_pixels_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          plane_byte,
	input  logic                                first_of_range,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [6:0]                          pixel_x,
	output logic [6:0]                          pixel_y,
	output logic [7:0]                          red,
	output logic [7:0]                          green,
	output logic [7:0]                          blue,
	output logic                                row_done,
	input  logic                                cfg_we,
	input  logic [ptrgb_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [ptrgb_pkg::COLOR_W-1:0]       cfg_data
);
	import ptrgb_pkg::*;

	palette_t     palette_q;
	logic [7:0]   start_tile_q;
	logic [3:0]   pos_q;
	logic [7:0]   slot_q;
	logic [7:0]   low_rows_q [8];

	logic         in_acc;
	logic [3:0]   eff_pos;
	logic [7:0]   eff_slot;
	logic         is_high;
	logic         job_valid;
	row_job_t     job;
	emit_status_t status;
	logic [TX_W-1:0] tile_x;
	logic [3:0]   tile_y;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_q    <= '0;
			start_tile_q <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLOR_ZERO:  palette_q[0] <= cfg_data;
				REG_COLOR_ONE:   palette_q[1] <= cfg_data;
				REG_COLOR_TWO:   palette_q[2] <= cfg_data;
				REG_COLOR_THREE: palette_q[3] <= cfg_data;
				REG_START_TILE:  start_tile_q <= cfg_data[7:0];
				default:         ;
			endcase
		end
	end

	// Accept whenever the emitter queue slot is open.
	assign in_stall = status.pend;
	assign in_acc   = in_valid && !in_stall;

	// A range restart takes effect before the byte is handled.
	assign eff_pos  = first_of_range ? 4'd0 : pos_q;
	assign eff_slot = first_of_range ? start_tile_q : slot_q;
	assign is_high  = eff_pos[3];

	// Sheet placement: sheet dimensions in tiles are powers of two.
	assign tile_x = TX_W'(eff_slot % TILES_PER_ROW);
	assign tile_y = 4'((eff_slot / TILES_PER_ROW) % TILES_PER_COL);

	assign job_valid = in_acc && is_high;
	assign job.hi    = plane_byte;
	assign job.lo    = low_rows_q[eff_pos[2:0]];
	assign job.tx    = tile_x;
	assign job.y     = {tile_y, eff_pos[2:0]};

	// Byte position and tile slot; position wraps from 15 to 0 on its own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 4'd0;
			slot_q <= 8'd0;
		end else if (in_acc) begin
			pos_q <= eff_pos + 4'd1;
			if (eff_pos == 4'd15) begin
				slot_q <= eff_slot + 8'd1;
			end else begin
				slot_q <= eff_slot;
			end
		end
	end

	// Low plane rows: written before read in every tile, so no reset.
	always_ff @(posedge clk) begin
		if (in_acc && !is_high) begin
			low_rows_q[eff_pos[2:0]] <= plane_byte;
		end
	end

	ptrgb_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.palette   (palette_q),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.row_done  (row_done)
	);

	// A row queued behind an idle emitter goes active on the next cycle.
	a_pend_needs_act: assert property (@(posedge clk) disable iff (!arst_n)
		(status.pend && !status.act) |=> status.act)
		else $error("queued row not moved into idle emitter");

	// row_done marks exactly the rightmost pixel of a tile row.
	a_row_done_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (row_done == (pixel_x[2:0] == 3'd7)))
		else $error("row_done out of step with pixel_x");

	// The last byte of a tile advances the slot by one.
	a_slot_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && eff_pos == 4'd15) |=> (slot_q == $past(eff_slot) + 8'd1))
		else $error("tile slot did not advance at end of tile");

	// A high-plane byte leaves the queue slot occupied.
	a_job_queued: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |=> status.pend)
		else $error("accepted row not queued");

endmodule

// ===== design/ptrgb_emit.sv =====
`timescale 1ns / 1ps
// Row emitter: one queued row job, one active row, and the pixel output register.
// Depends on ptrgb_pkg for the job, palette and status types.
module ptrgb_emit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     job_valid,
	input  ptrgb_pkg::row_job_t      job,
	input  ptrgb_pkg::palette_t      palette,
	output ptrgb_pkg::emit_status_t  status,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [6:0]               pixel_x,
	output logic [6:0]               pixel_y,
	output logic [7:0]               red,
	output logic [7:0]               green,
	output logic [7:0]               blue,
	output logic                     row_done
);
	import ptrgb_pkg::*;

	row_job_t           pend_q;
	row_job_t           job_q;
	logic               pend_valid_q;
	logic               act_q;
	logic [2:0]         k_q;
	logic               out_valid_q;
	logic               load_out;
	logic               emit;
	logic               act_free;
	logic [2:0]         bit_sel;
	logic [1:0]         pix_idx;
	logic [COLOR_W-1:0] rgb;

	assign load_out = !out_valid_q || !out_stall;
	assign emit     = act_q && load_out;
	assign act_free = !act_q || (emit && (k_q == 3'd7));
	assign bit_sel  = ~k_q;
	assign pix_idx  = {job_q.hi[bit_sel], job_q.lo[bit_sel]};
	assign rgb      = palette[pix_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			act_q        <= 1'b0;
			k_q          <= 3'd0;
			out_valid_q  <= 1'b0;
		end else begin
			if (job_valid) begin
				pend_valid_q <= 1'b1;
			end else if (act_free && pend_valid_q) begin
				pend_valid_q <= 1'b0;
			end
			if (act_free) begin
				act_q <= pend_valid_q;
				k_q   <= 3'd0;
			end else if (emit) begin
				k_q <= k_q + 3'd1;
			end
			if (load_out) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid) begin
			pend_q <= job;
		end
		if (act_free && pend_valid_q) begin
			job_q <= pend_q;
		end
		if (emit) begin
			pixel_x  <= {job_q.tx, k_q};
			pixel_y  <= job_q.y;
			red      <= rgb[23:16];
			green    <= rgb[15:8];
			blue     <= rgb[7:0];
			row_done <= (k_q == 3'd7);
		end
	end

	assign out_valid   = out_valid_q;
	assign status.pend = pend_valid_q;
	assign status.act  = act_q;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for planar_tile_to_rgb_pixels_top.
// Depends on ptrgb_pkg and the decoder RTL; holds its own tile decoder to predict every pixel.
module tb;
	import ptrgb_pkg::*;

	// One tile byte waiting to go out, with the idle cycles to hold before it.
	typedef struct {
		logic [7:0] data;
		logic       first;
		int         gap;
	} tile_byte_t;

	// One expected pixel transaction.
	typedef struct {
		logic [6:0] x;
		logic [6:0] y;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       done;
	} pixel_t;

	// Idle styles for both sides: none, uniform 0..15, or mostly none with rare long holds.
	localparam int IDLE_NONE   = 0;
	localparam int IDLE_RANDOM = 1;
	localparam int IDLE_RARE   = 2;

	localparam int PHASES          = 6;
	localparam int BYTES_PER_PHASE = 35;
	localparam int DRAIN_CYCLES    = 10;
	localparam int MAX_REPORTS     = 20;

	// Directed tile data: a full tile at the last slot, then the low plane and one row
	// of the following tile so the slot wraps from 255 to 0.
	localparam logic [0:24][7:0] DIRECTED = {
		8'h00, 8'hff, 8'haa, 8'h55, 8'hf0, 8'h0f, 8'h81, 8'h7e,
		8'h00, 8'hff, 8'h55, 8'haa, 8'hff, 8'h00, 8'h3c, 8'hc3,
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
		8'h80
	};

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_stall;
	logic [7:0]  plane_byte     = 8'h00;
	logic        first_of_range = 1'b0;
	logic        out_valid;
	logic        out_stall      = 1'b0;
	logic [6:0]  pixel_x;
	logic [6:0]  pixel_y;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        row_done;
	logic        cfg_we         = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [COLOR_W-1:0]   cfg_data  = '0;

	// Predictor state: palette, start slot, stored low plane, byte position and tile slot.
	logic [COLOR_W-1:0] palette [4];
	logic [7:0]         sheet_start = 8'h00;
	logic [7:0]         low_rows [8];
	logic [3:0]         byte_idx = 4'd0;
	logic [7:0]         slot_now = 8'h00;

	tile_byte_t bytes_to_send [$];
	pixel_t     pixels_due [$];
	tile_byte_t next_byte;
	pixel_t     got_pixel;
	pixel_t     want_pixel;

	int tx_mode = IDLE_NONE;
	int rx_mode = IDLE_NONE;
	int stall_left = 0;
	int errors = 0;
	int bytes_queued = 0;
	int bytes_taken = 0;
	int pixels_checked = 0;
	int reg_writes = 0;

	planar_tile_to_rgb_pixels_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.plane_byte    (plane_byte),
		.first_of_range(first_of_range),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.row_done      (row_done),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int draw_wait(input int mode);
		if (mode == IDLE_RANDOM)
			return $urandom_range(0, 15);
		if (mode == IDLE_RARE)
			return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
		return 0;
	endfunction

	// Bias data toward all-zero and all-one rows so every palette index shows up often.
	function automatic logic [7:0] draw_byte();
		int pick;
		pick = $urandom_range(0, 5);
		if (pick == 0)
			return 8'h00;
		if (pick == 1)
			return 8'hff;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [COLOR_W-1:0] draw_color();
		int pick;
		pick = $urandom_range(0, 3);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return COLOR_W'($urandom_range(0, 24'hffffff));
	endfunction

	// Advance the predictor by one accepted tile byte and queue the pixels it yields.
	task automatic decode_byte(input logic [7:0] data, input logic first);
		int         row;
		int         tx;
		int         ty;
		logic [1:0] sel;
		logic [23:0] rgb;
		pixel_t     px;
		if (first) begin
			byte_idx = 4'd0;
			slot_now = sheet_start;
		end
		// Low plane: store the row, nothing comes out.
		if (byte_idx < 4'd8) begin
			low_rows[byte_idx[2:0]] = data;
			byte_idx = byte_idx + 4'd1;
			return;
		end
		row = int'(byte_idx) - 8;
		tx  = int'(slot_now) % TILES_PER_ROW;
		ty  = (int'(slot_now) / TILES_PER_ROW) % TILES_PER_COL;
		for (int k = 0; k < 8; k++) begin
			sel     = {data[7 - k], low_rows[row][7 - k]};
			rgb     = palette[sel];
			px.x    = 7'((tx * 8 + k) & 'h7f);
			px.y    = 7'((ty * 8 + row) & 'h7f);
			px.r    = rgb[23:16];
			px.g    = rgb[15:8];
			px.b    = rgb[7:0];
			px.done = (k == 7);
			pixels_due.push_back(px);
		end
		// Advance the byte position; at the end of a tile it wraps and the slot steps on.
		byte_idx = byte_idx + 4'd1;
		if (byte_idx == 4'd0)
			slot_now = slot_now + 8'd1;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t ns: %s mismatch on pixel %0d: expected %0h, actual %0h",
					$time, name, pixels_checked, want, got);
		end
	endtask

	// Issue one register write and mirror it in the predictor. The block is idle here.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] value);
		if (idx <= REG_COLOR_THREE)
			palette[idx[1:0]] = value;
		else if (idx == REG_START_TILE)
			sheet_start = value[7:0];
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		reg_writes++;
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until every queued byte is taken and every pixel is out, then let the pipe drain.
	task automatic wait_idle();
		while (bytes_taken != bytes_queued || pixels_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_byte(input logic [7:0] data, input logic first);
		tile_byte_t item;
		item.data  = data;
		item.first = first;
		item.gap   = draw_wait(tx_mode);
		bytes_to_send.push_back(item);
		bytes_queued++;
	endtask

	// Fill one phase: mostly whole tiles with random content, the rest short broken
	// runs with restarts anywhere in the tile; the last run is cut to land on the count.
	task automatic queue_phase(input int count);
		int   added;
		int   len;
		logic restart;
		added = 0;
		while (added < count) begin
			if ($urandom_range(0, 9) < 8) begin
				len     = 16 * $urandom_range(1, 2);
				if (len > count - added)
					len = count - added;
				restart = ($urandom_range(0, 3) != 0);
				for (int i = 0; i < len; i++)
					push_byte(draw_byte(), restart && i == 0);
			end else begin
				len = $urandom_range(1, 20);
				if (len > count - added)
					len = count - added;
				for (int i = 0; i < len; i++)
					push_byte(draw_byte(), $urandom_range(0, 3) == 0);
			end
			added += len;
		end
	endtask

	// Input driver: predict on every accepted transaction, then present the next byte
	// once its idle count has run out. Keep valid high across back-to-back bytes.
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			decode_byte(plane_byte, first_of_range);
			bytes_taken++;
		end
		if (!in_valid || !in_stall) begin
			if (arst_n && bytes_to_send.size() != 0 && bytes_to_send[0].gap == 0) begin
				next_byte      = bytes_to_send.pop_front();
				in_valid       <= 1'b1;
				plane_byte     <= next_byte.data;
				first_of_range <= next_byte.first;
			end else begin
				if (arst_n && bytes_to_send.size() != 0)
					bytes_to_send[0].gap = bytes_to_send[0].gap - 1;
				in_valid <= 1'b0;
			end
		end
	end

	// Output monitor: compare each accepted pixel with the oldest expectation, then
	// draw a fresh stall count for the next one. The count runs down whether or not a
	// pixel is waiting, so stalls land on every phase of the emitter.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_pixel.x    = pixel_x;
			got_pixel.y    = pixel_y;
			got_pixel.r    = red;
			got_pixel.g    = green;
			got_pixel.b    = blue;
			got_pixel.done = row_done;
			if (pixels_due.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t ns: pixel with none expected: x %0h y %0h rgb %02h%02h%02h",
						$time, pixel_x, pixel_y, red, green, blue);
			end else begin
				want_pixel = pixels_due.pop_front();
				check_field("pixel_x", want_pixel.x, got_pixel.x);
				check_field("pixel_y", want_pixel.y, got_pixel.y);
				check_field("red", want_pixel.r, got_pixel.r);
				check_field("green", want_pixel.g, got_pixel.g);
				check_field("blue", want_pixel.b, got_pixel.b);
				check_field("row_done", want_pixel.done, got_pixel.done);
			end
			pixels_checked++;
			stall_left = draw_wait(rx_mode);
		end
		if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left = stall_left - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		for (int i = 0; i < 4; i++)
			palette[i] = '0;
		for (int i = 0; i < 8; i++)
			low_rows[i] = 8'h00;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: distinct palette with both extremes, start at the last slot so the
		// tile counter wraps; the unused indexes must leave everything untouched.
		write_reg(REG_COLOR_ZERO, 24'h000000);
		write_reg(REG_COLOR_ONE, 24'hffffff);
		write_reg(REG_COLOR_TWO, 24'ha5c31e);
		write_reg(REG_COLOR_THREE, 24'h5a3ce1);
		write_reg(REG_START_TILE, 24'h0000ff);
		for (int i = REG_START_TILE + 1; i < (1 << REG_IDX_W); i++)
			write_reg(REG_IDX_W'(i), draw_color());
		end_writes();
		tx_mode = IDLE_RARE;
		rx_mode = IDLE_RANDOM;
		for (int i = 0; i < 25; i++)
			push_byte(DIRECTED[i], i == 0);
		wait_idle();

		// Random phases: new palette and start slot each time, both slot extremes
		// included, and three pairings of idle styles on the two sides.
		for (int ph = 0; ph < PHASES; ph++) begin
			write_reg(REG_COLOR_ZERO, draw_color());
			write_reg(REG_COLOR_ONE, draw_color());
			write_reg(REG_COLOR_TWO, draw_color());
			write_reg(REG_COLOR_THREE, draw_color());
			if (ph == 0)
				write_reg(REG_START_TILE, '0);
			else if (ph == 1)
				write_reg(REG_START_TILE, 24'h0000ff);
			else
				write_reg(REG_START_TILE, COLOR_W'($urandom_range(0, 255)));
			if ($urandom_range(0, 1) == 1)
				write_reg(REG_IDX_W'($urandom_range(REG_START_TILE + 1, (1 << REG_IDX_W) - 1)),
					draw_color());
			end_writes();
			tx_mode = ph % 3;
			rx_mode = (ph + 1) % 3;
			queue_phase(BYTES_PER_PHASE);
			wait_idle();
		end

		if (pixels_due.size() != 0) begin
			errors++;
			$display("%0t ns: %0d expected pixels never arrived", $time, pixels_due.size());
		end
		$display("Covered %0d tile bytes and %0d pixels with %0d register writes,", bytes_taken,
			pixels_checked, reg_writes);
		$display("%0d palette settings, mixed sender gaps and receiver stalls.", PHASES + 1);
		if (errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

	// Drop the run if the block hangs; this is many times the slowest correct run.
	initial begin
		#5_000_000;
		$display("Timed out with %0d pixels still expected", pixels_due.size());
		$display("tb: errors");
		$finish;
	end

endmodule
